// ===== hdl/ckot_pkg.sv =====
// shared constants and types for the composite key ordinal table
package ckot_pkg;

  localparam int MAX_KEYS_DEF  = 256;
  localparam int KEY_PARTS_DEF = 4;
  localparam int PART_W        = 64;
  localparam int IN_PARTS      = 4;
  localparam int CFG_W         = 3;
  localparam int RIDX_W        = 8;
  localparam int ORD_W         = 8;
  localparam int IN_DATA_W     = 264;
  localparam int OUT_DATA_W    = 272;

  localparam logic CMD_ACC  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [CFG_W-1:0] CFG_PARTS_RST = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ
  } ckot_state_t;

endpackage

// ===== hdl/ckot_ram.sv =====
// key store memory, one write port and one registered read port
module ckot_ram
  import ckot_pkg::*;
#(
  parameter int DEPTH = MAX_KEYS_DEF,
  parameter int WIDTH = KEY_PARTS_DEF * PART_W,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/composite_key_ordinal_table.sv =====
// composite key to dense ordinal table, top level
// accumulate item: linear scan of the key memory, one stored key per cycle,
//   result register loaded on the first match or once all n stored keys are checked
// read item: one memory read, result loaded from the ST_READ state in the cycle after accept
// one item at a time; next item taken once the result register is free or taken
// synchronous active-low reset clears the key count and sets four key parts
module composite_key_ordinal_table
  import ckot_pkg::*;
#(
  parameter int MAX_KEYS  = MAX_KEYS_DEF,
  parameter int KEY_PARTS = KEY_PARTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data,    // key_parts_used
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,    // key_part_a, b, c, d, read_index
  input  logic                  in_tuser,    // cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata    // ordinal, is_new, table_full,
                                             // read_valid, out_part_a, b, c, d, zero pad
);

  localparam int IDX_W  = $clog2(MAX_KEYS);
  localparam int CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int CMP_W  = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
  localparam int WORD_W = KEY_PARTS * PART_W;

  ckot_state_t state_r, state_nxt;
  logic [CFG_W-1:0]   cfg_r;
  logic [CFG_W-1:0]   used;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   iss_r, iss_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic [PART_W-1:0]  key_r [KEY_PARTS];
  logic [PART_W-1:0]  key_nxt [KEY_PARTS];
  logic [PART_W-1:0]  in_part [IN_PARTS];
  logic [RIDX_W-1:0]  in_ridx;
  logic [CMP_W-1:0]   ridx_ext;
  logic [CMP_W-1:0]   ord_ext;

  logic               out_vld_r, out_vld_nxt;
  logic [ORD_W-1:0]   ord_r, ord_nxt;
  logic               new_r, new_nxt, full_r, full_nxt, rval_r, rval_nxt;
  logic [PART_W-1:0]  opart_r [IN_PARTS];
  logic [PART_W-1:0]  opart_nxt [IN_PARTS];

  logic               we, re, match, in_acc;
  logic [IDX_W-1:0]   waddr, raddr;
  logic [WORD_W-1:0]  wdata, rdata;

  ckot_ram #(.DEPTH(MAX_KEYS), .WIDTH(WORD_W), .AW(IDX_W)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE) && (!out_vld_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    for (int p = 0; p < IN_PARTS; p++) begin
      in_part[p] = in_tdata[p*PART_W +: PART_W];
    end
  end
  assign in_ridx  = in_tdata[IN_PARTS*PART_W +: RIDX_W];
  assign ridx_ext = CMP_W'(in_ridx);
  assign ord_ext  = CMP_W'(chk_idx_r);

  always_comb begin
    if (cfg_r == '0) begin
      used = CFG_W'(1);
    end else if (cfg_r > CFG_W'(KEY_PARTS)) begin
      used = CFG_W'(KEY_PARTS);
    end else begin
      used = cfg_r;
    end
  end

  always_comb begin
    match = chk_vld_r;
    for (int p = 0; p < KEY_PARTS; p++) begin
      if ((CFG_W'(p) < used) && (rdata[p*PART_W +: PART_W] != key_r[p])) begin
        match = 1'b0;
      end
    end
    for (int p = 0; p < KEY_PARTS; p++) begin
      wdata[p*PART_W +: PART_W] = key_r[p];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    iss_nxt     = iss_r;
    chk_vld_nxt = 1'b0;
    chk_idx_nxt = chk_idx_r;
    key_nxt     = key_r;
    out_vld_nxt = out_vld_r && !out_tready;
    ord_nxt     = ord_r;
    new_nxt     = new_r;
    full_nxt    = full_r;
    rval_nxt    = rval_r;
    opart_nxt   = opart_r;
    we          = 1'b0;
    waddr       = cnt_r[IDX_W-1:0];
    re          = 1'b0;
    raddr       = iss_r[IDX_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          for (int p = 0; p < KEY_PARTS; p++) begin
            key_nxt[p] = (CFG_W'(p) < used) ? in_part[p] : '0;
          end
          if (in_tuser == CMD_READ) begin
            rval_nxt  = ridx_ext < CMP_W'(cnt_r);
            re        = 1'b1;
            raddr     = IDX_W'(ridx_ext);
            state_nxt = ST_READ;
          end else begin
            iss_nxt   = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (match) begin
          ord_nxt     = ord_ext[ORD_W-1:0];
          new_nxt     = 1'b0;
          full_nxt    = 1'b0;
          rval_nxt    = 1'b0;
          opart_nxt   = '{default: '0};
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (iss_r < cnt_r) begin
          re          = 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = iss_r[IDX_W-1:0];
          iss_nxt     = iss_r + CNT_W'(1);
        end else begin
          rval_nxt    = 1'b0;
          opart_nxt   = '{default: '0};
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
          if (cnt_r == CNT_W'(MAX_KEYS)) begin
            ord_nxt  = '0;
            new_nxt  = 1'b0;
            full_nxt = 1'b1;
          end else begin
            we       = 1'b1;
            ord_nxt  = ORD_W'(cnt_r);
            new_nxt  = 1'b1;
            full_nxt = 1'b0;
            cnt_nxt  = cnt_r + CNT_W'(1);
          end
        end
      end
      ST_READ: begin
        ord_nxt  = '0;
        new_nxt  = 1'b0;
        full_nxt = 1'b0;
        for (int p = 0; p < IN_PARTS; p++) begin
          opart_nxt[p] = '0;
          if (p < KEY_PARTS && rval_r) begin
            opart_nxt[p] = rdata[p*PART_W +: PART_W];
          end
        end
        out_vld_nxt = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cfg_r     <= CFG_PARTS_RST;
      cnt_r     <= '0;
      iss_r     <= '0;
      chk_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      iss_r     <= iss_nxt;
      chk_vld_r <= chk_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= chk_idx_nxt;
    key_r     <= key_nxt;
    ord_r     <= ord_nxt;
    new_r     <= new_nxt;
    full_r    <= full_nxt;
    rval_r    <= rval_nxt;
    opart_r   <= opart_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, opart_r[3], opart_r[2], opart_r[1], opart_r[0],
                       rval_r, full_r, new_r, ord_r};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_KEYS)) else $error("key count above table size");

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> cnt_r < CNT_W'(MAX_KEYS)) else $error("insert into full table");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(new_r && full_r)) else $error("is_new with table_full");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> iss_r <= cnt_r) else $error("scan past stored keys");

endmodule

// ===== sim/composite_key_ordinal_table_tb.sv =====
// testbench for the composite key ordinal table: directed table and random traffic
module composite_key_ordinal_table_tb;
  import ckot_pkg::*;

  localparam int TABLE_SIZE = 256;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 1280;

  typedef struct {
    logic        cmd;
    logic [63:0] part [4];
    logic [7:0]  ridx;
  } key_item_t;

  typedef struct {
    logic [7:0]  ordinal;
    logic        is_new;
    logic        table_full;
    logic        read_valid;
    logic [63:0] part [4];
  } ordinal_reply_t;

  typedef struct {
    logic        cfg;
    logic [2:0]  cfg_val;
    key_item_t   it;
    logic        has_lit;
    logic [7:0]  lit_ord;
    logic        lit_new;
    logic        lit_full;
    logic        lit_rv;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  logic [63:0] stored_keys [TABLE_SIZE][4];
  int unsigned key_count;
  int unsigned parts_reg;
  ordinal_reply_t expected_replies [$];
  stim_row_t table_rows [$];
  int mismatches = 0;
  int replies_seen = 0;
  int full_seen = 0;
  int reads_valid_seen = 0;
  int long_hold = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  longint unsigned cycles = 0;
  logic [63:0] pool [16];

  composite_key_ordinal_table dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic ordinal_reply_t lookup_ordinal(key_item_t it);
    ordinal_reply_t r;
    logic [63:0] k [4];
    int unsigned used;
    bit hit;
    r.ordinal = '0; r.is_new = 0; r.table_full = 0; r.read_valid = 0;
    for (int p = 0; p < 4; p++) r.part[p] = '0;
    used = (parts_reg == 0) ? 1 : (parts_reg > 4 ? 4 : parts_reg);
    if (it.cmd == CMD_READ) begin
      if (it.ridx < key_count) begin
        r.read_valid = 1;
        for (int p = 0; p < 4; p++) r.part[p] = stored_keys[it.ridx][p];
      end
      return r;
    end
    for (int p = 0; p < 4; p++) k[p] = (p < used) ? it.part[p] : 64'd0;
    for (int i = 0; i < key_count; i++) begin
      hit = 1;
      for (int p = 0; p < used; p++)
        if (stored_keys[i][p] != k[p]) hit = 0;
      if (hit) begin
        r.ordinal = i[7:0];
        return r;
      end
    end
    if (key_count >= TABLE_SIZE) begin
      r.table_full = 1;
      return r;
    end
    for (int p = 0; p < 4; p++) stored_keys[key_count][p] = k[p];
    r.ordinal = key_count[7:0];
    r.is_new = 1;
    key_count++;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h (reply %0d)", what, got, want, replies_seen);
    mismatches++;
  endtask

  task automatic send_item(key_item_t it, bit has_lit, ordinal_reply_t lit);
    ordinal_reply_t r;
    r = lookup_ordinal(it);
    if (has_lit) begin
      if (r.ordinal != lit.ordinal || r.is_new != lit.is_new ||
          r.table_full != lit.table_full || r.read_valid != lit.read_valid)
        report_mismatch("directed row", {r.ordinal, r.is_new, r.table_full, r.read_valid},
                        {lit.ordinal, lit.is_new, lit.table_full, lit.read_valid});
    end
    expected_replies.insert(expected_replies.size(), r);
    in_tvalid <= 1'b1;
    in_tuser <= it.cmd;
    in_tdata <= {it.ridx, it.part[3], it.part[2], it.part[1], it.part[0]};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drop_valid();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (TABLE_SIZE + 20) @(posedge clk);
  endtask

  task automatic write_parts(logic [2:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    parts_reg = v;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic key_item_t rand_item(int unsigned read_pct);
    key_item_t it;
    it.cmd = ($urandom_range(99) < read_pct) ? CMD_READ : CMD_ACC;
    for (int p = 0; p < 4; p++) begin
      case ($urandom_range(3))
        0: it.part[p] = rand64();
        default: it.part[p] = pool[$urandom_range(15)];
      endcase
    end
    it.ridx = $urandom_range(255);
    return it;
  endfunction

  // receiver: random stall pattern, with one long hold-off
  always @(posedge clk) begin
    if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_tready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      long_hold <= 400;
      hold_done <= 1'b1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(3) != 0) || ($urandom_range(1) == 0);
    end
  end

  always @(posedge clk) begin
    ordinal_reply_t e;
    ordinal_reply_t g;
    if (rst_n && out_tvalid && out_tready) begin
      g.ordinal = out_tdata[7:0];
      g.is_new = out_tdata[8];
      g.table_full = out_tdata[9];
      g.read_valid = out_tdata[10];
      for (int p = 0; p < 4; p++) g.part[p] = out_tdata[11 + 64*p +: 64];
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected reply", out_tdata[63:0], 64'd0);
      end else begin
        e = expected_replies.pop_front();
        if (g.ordinal != e.ordinal) report_mismatch("ordinal", g.ordinal, e.ordinal);
        if (g.is_new != e.is_new) report_mismatch("is_new", g.is_new, e.is_new);
        if (g.table_full != e.table_full)
          report_mismatch("table_full", g.table_full, e.table_full);
        if (g.read_valid != e.read_valid)
          report_mismatch("read_valid", g.read_valid, e.read_valid);
        for (int p = 0; p < 4; p++)
          if (g.part[p] != e.part[p]) report_mismatch("out_part", g.part[p], e.part[p]);
      end
      replies_seen <= replies_seen + 1;
      if (g.table_full) full_seen <= full_seen + 1;
      if (g.read_valid) reads_valid_seen <= reads_valid_seen + 1;
    end
  end

  function automatic stim_row_t mk_row(logic cmd, logic [63:0] a, logic [63:0] b,
                                       logic [63:0] c, logic [63:0] d, logic [7:0] ridx,
                                       bit lit, logic [7:0] o, logic n, logic f, logic v);
    stim_row_t s;
    s.cfg = 0; s.cfg_val = '0;
    s.it.cmd = cmd; s.it.part[0] = a; s.it.part[1] = b; s.it.part[2] = c;
    s.it.part[3] = d; s.it.ridx = ridx;
    s.has_lit = lit; s.lit_ord = o; s.lit_new = n; s.lit_full = f; s.lit_rv = v;
    return s;
  endfunction

  function automatic stim_row_t cfg_row(logic [2:0] v);
    stim_row_t s;
    s = mk_row(CMD_ACC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    s.cfg = 1; s.cfg_val = v;
    return s;
  endfunction

  function automatic void add_row(stim_row_t s);
    table_rows.insert(table_rows.size(), s);
  endfunction

  initial begin
    ordinal_reply_t lit;
    key_item_t it;
    int burst;
    int gap;
    logic [63:0] ones;
    ones = '1;
    key_count = 0;
    parts_reg = 4;
    for (int i = 0; i < 16; i++) pool[i] = (i < 2) ? (i == 0 ? 64'd0 : ones) : rand64();

    add_row(mk_row(CMD_READ, 0, 0, 0, 0, 8'd0, 1, 0, 0, 0, 0));
    add_row(mk_row(CMD_ACC, 0, 0, 0, 0, 8'd0, 1, 0, 1, 0, 0));
    add_row(mk_row(CMD_ACC, ones, ones, ones, ones, 8'hff, 1, 1, 1, 0, 0));
    add_row(mk_row(CMD_ACC, 0, 0, 0, 0, 8'd0, 1, 0, 0, 0, 0));
    add_row(mk_row(CMD_ACC, ones, ones, ones, 0, 8'd0, 1, 2, 1, 0, 0));
    add_row(mk_row(CMD_READ, 0, 0, 0, 0, 8'd1, 1, 0, 0, 0, 1));
    add_row(mk_row(CMD_READ, ones, ones, ones, ones, 8'd3, 1, 0, 0, 0, 0));
    add_row(mk_row(CMD_READ, 0, 0, 0, 0, 8'hff, 1, 0, 0, 0, 0));
    add_row(cfg_row(3'd1));
    add_row(mk_row(CMD_ACC, ones, 5, 6, 7, 8'd0, 1, 1, 0, 0, 0));
    add_row(mk_row(CMD_ACC, 64'h1234, 5, 6, 7, 8'd0, 1, 3, 1, 0, 0));
    add_row(mk_row(CMD_READ, 0, 0, 0, 0, 8'd3, 1, 0, 0, 0, 1));
    add_row(cfg_row(3'd0));
    add_row(mk_row(CMD_ACC, 64'h1234, 9, 9, 9, 8'd0, 1, 3, 0, 0, 0));
    add_row(cfg_row(3'd7));
    add_row(mk_row(CMD_ACC, 64'h1234, 0, 0, 0, 8'd0, 1, 3, 0, 0, 0));
    add_row(cfg_row(3'd2));
    add_row(mk_row(CMD_ACC, 64'h8000000000000001, 64'h5a5a, 1, 1, 0,
                   0, 0, 0, 0, 0));
    add_row(mk_row(CMD_READ, 0, 0, 0, 0, 8'd4, 0, 0, 0, 0, 0));
    add_row(cfg_row(3'd4));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_rows[i]) begin
      if (table_rows[i].cfg) begin
        write_parts(table_rows[i].cfg_val);
      end else begin
        lit.ordinal = table_rows[i].lit_ord; lit.is_new = table_rows[i].lit_new;
        lit.table_full = table_rows[i].lit_full; lit.read_valid = table_rows[i].lit_rv;
        send_item(table_rows[i].it, table_rows[i].has_lit, lit);
        drop_valid();
      end
    end

    // random phases over several part counts; the table fills toward the end
    for (int ph = 0; ph < 8; ph++) begin
      write_parts(ph == 7 ? 3'd4 : 3'($urandom_range(7)));
      if (ph == 3) hold_go = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS / 8; ) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(9) == 0) burst = 40;
        for (int b = 0; b < burst && n < RANDOM_ITEMS / 8; b++, n++) begin
          it = rand_item(ph < 5 ? 30 : 15);
          if (ph >= 5 && $urandom_range(1)) for (int p = 0; p < 4; p++) it.part[p] = rand64();
          send_item(it, 0, lit);
        end
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        if (ph == 2 && n >= 80 && n - burst < 80) begin
          in_tvalid <= 1'b0;
          while (expected_replies.size() != 0) @(posedge clk);
          @(posedge clk);
        end
      end
      in_tvalid <= 1'b0;
    end

    // push past capacity so full-table lookups are covered
    for (int extra = 0; extra < 4; ) begin
      it = rand_item(0);
      for (int p = 0; p < 4; p++) it.part[p] = rand64();
      if (key_count >= TABLE_SIZE) extra++;
      send_item(it, 0, lit);
    end
    for (int i = 0; i < 10; i++) begin
      it = rand_item(50);
      it.part[0] = stored_keys[i][0]; it.part[1] = stored_keys[i][1];
      it.part[2] = stored_keys[i][2]; it.part[3] = stored_keys[i][3];
      send_item(it, 0, lit);
    end
    in_tvalid <= 1'b0;

    drain();
    $display("covered %0d replies, %0d keys stored, %0d full-table refusals, %0d valid reads",
             replies_seen, key_count, full_seen, reads_valid_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
